/* rtl/core/sstf_pkg.sv */
// Shared constants and types for the shortest-seek-time-first scheduler.
`timescale 1ns / 1ps

package sstf_pkg;

    localparam int DEF_QUEUE_DEPTH = 32;
    localparam int DEF_SECTOR_BITS = 48;
    localparam int DEF_TAG_BITS    = 8;

    localparam logic [1:0] STATUS_ADDED      = 2'd0;
    localparam logic [1:0] STATUS_DISPATCHED = 2'd1;
    localparam logic [1:0] STATUS_EMPTY      = 2'd2;
    localparam logic [1:0] STATUS_FULL       = 2'd3;

    localparam logic OP_ADD      = 1'b0;
    localparam logic OP_DISPATCH = 1'b1;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_SCAN,
        SEQ_SHIFT
    } seq_state_t;

endpackage

/* rtl/core/sstf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module sstf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/sstf_request_scheduler.sv */
// Shortest-seek-time-first request queue with a sequenced scan-and-compact unit.
// Add, refused add and empty dispatch: result strobed on done in the cycle after start.
// Dispatch of n queued requests: the RAM port scans all n, then moves the entries behind
//   the chosen slot k down one (none for the tail); done is strobed when the moves end.
// done is a single-cycle strobe; results cannot be stalled by the receiver.
// Reset clears the request count and head position; queue RAM contents are left as is.
`timescale 1ns / 1ps

module sstf_request_scheduler #(
    parameter int QUEUE_DEPTH = sstf_pkg::DEF_QUEUE_DEPTH,
    parameter int SECTOR_BITS = sstf_pkg::DEF_SECTOR_BITS,
    parameter int TAG_BITS    = sstf_pkg::DEF_TAG_BITS,
    localparam int CNT_BITS   = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   op,
    input  logic [SECTOR_BITS-1:0] request_sector,
    input  logic [TAG_BITS-1:0]    request_tag,
    output logic                   done,
    output logic [1:0]             status,
    output logic [SECTOR_BITS-1:0] chosen_sector,
    output logic [TAG_BITS-1:0]    chosen_tag,
    output logic [SECTOR_BITS-1:0] seek_distance,
    output logic [CNT_BITS-1:0]    pending_count
);

    localparam int ADDR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int DATA_BITS = SECTOR_BITS + TAG_BITS;

    sstf_pkg::seq_state_t state_reg, state_next;

    logic [CNT_BITS-1:0]    occ_reg, occ_next;
    logic [SECTOR_BITS-1:0] head_reg, head_next;
    logic [CNT_BITS-1:0]    iss_reg, iss_next;
    logic                   v1_reg, v1_next;
    logic                   v2_reg, v2_next;
    logic                   best_valid_reg, best_valid_next;
    logic                   done_reg, done_next;

    logic [ADDR_BITS-1:0]   idx1_reg, idx1_next;
    logic [ADDR_BITS-1:0]   idx2_reg, idx2_next;
    logic [SECTOR_BITS-1:0] dist_reg, dist_next;
    logic [DATA_BITS-1:0]   data2_reg, data2_next;
    logic [ADDR_BITS-1:0]   best_idx_reg, best_idx_next;
    logic [SECTOR_BITS-1:0] best_dist_reg, best_dist_next;
    logic [DATA_BITS-1:0]   best_data_reg, best_data_next;

    logic [1:0]             status_reg, status_next;
    logic [SECTOR_BITS-1:0] sector_reg, sector_next;
    logic [TAG_BITS-1:0]    tag_reg, tag_next;
    logic [SECTOR_BITS-1:0] seek_reg, seek_next;
    logic [CNT_BITS-1:0]    pend_reg, pend_next;

    logic                   ram_we;
    logic [ADDR_BITS-1:0]   ram_waddr;
    logic [DATA_BITS-1:0]   ram_wdata;
    logic [ADDR_BITS-1:0]   ram_raddr;
    logic [DATA_BITS-1:0]   ram_rdata;

    logic [SECTOR_BITS:0]   diff;
    logic [SECTOR_BITS-1:0] gap;

    sstf_ram #(
        .WIDTH (DATA_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // shared distance unit: |head - sector|
    assign diff = {1'b0, head_reg} - {1'b0, ram_rdata[DATA_BITS-1:TAG_BITS]};
    assign gap  = diff[SECTOR_BITS] ? (~diff[SECTOR_BITS-1:0] + 1'b1)
                                    : diff[SECTOR_BITS-1:0];

    always_comb
    begin
        state_next      = state_reg;
        occ_next        = occ_reg;
        head_next       = head_reg;
        iss_next        = iss_reg;
        v1_next         = v1_reg;
        v2_next         = v2_reg;
        best_valid_next = best_valid_reg;
        done_next       = 1'b0;
        idx1_next       = idx1_reg;
        idx2_next       = idx2_reg;
        dist_next       = dist_reg;
        data2_next      = data2_reg;
        best_idx_next   = best_idx_reg;
        best_dist_next  = best_dist_reg;
        best_data_next  = best_data_reg;
        status_next     = status_reg;
        sector_next     = sector_reg;
        tag_next        = tag_reg;
        seek_next       = seek_reg;
        pend_next       = pend_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = '0;
        ram_raddr       = '0;

        case (state_reg)
            sstf_pkg::SEQ_IDLE:
            begin
                if (start)
                begin
                    sector_next = '0;
                    tag_next    = '0;
                    seek_next   = '0;
                    if (op == sstf_pkg::OP_ADD)
                    begin
                        done_next = 1'b1;
                        if (occ_reg < CNT_BITS'(QUEUE_DEPTH))
                        begin
                            ram_we      = 1'b1;
                            ram_waddr   = occ_reg[ADDR_BITS-1:0];
                            ram_wdata   = {request_sector, request_tag};
                            occ_next    = occ_reg + 1'b1;
                            status_next = sstf_pkg::STATUS_ADDED;
                            pend_next   = occ_reg + 1'b1;
                        end
                        else
                        begin
                            status_next = sstf_pkg::STATUS_FULL;
                            pend_next   = occ_reg;
                        end
                    end
                    else if (occ_reg == '0)
                    begin
                        done_next   = 1'b1;
                        status_next = sstf_pkg::STATUS_EMPTY;
                        pend_next   = '0;
                    end
                    else
                    begin
                        state_next      = sstf_pkg::SEQ_SCAN;
                        iss_next        = '0;
                        v1_next         = 1'b0;
                        v2_next         = 1'b0;
                        best_valid_next = 1'b0;
                    end
                end
            end

            sstf_pkg::SEQ_SCAN:
            begin
                if (iss_reg < occ_reg)
                begin
                    ram_raddr = iss_reg[ADDR_BITS-1:0];
                    iss_next  = iss_reg + 1'b1;
                    v1_next   = 1'b1;
                    idx1_next = iss_reg[ADDR_BITS-1:0];
                end
                else
                begin
                    v1_next = 1'b0;
                end

                v2_next = v1_reg;
                if (v1_reg)
                begin
                    dist_next  = gap;
                    data2_next = ram_rdata;
                    idx2_next  = idx1_reg;
                end

                // strict compare keeps the oldest on a tie
                if (v2_reg && (!best_valid_reg || (dist_reg < best_dist_reg)))
                begin
                    best_valid_next = 1'b1;
                    best_idx_next   = idx2_reg;
                    best_dist_next  = dist_reg;
                    best_data_next  = data2_reg;
                end

                if ((iss_reg == occ_reg) && !v1_reg && !v2_reg)
                begin
                    state_next = sstf_pkg::SEQ_SHIFT;
                    iss_next   = CNT_BITS'(best_idx_reg) + 1'b1;
                end
            end

            sstf_pkg::SEQ_SHIFT:
            begin
                if (iss_reg < occ_reg)
                begin
                    ram_raddr = iss_reg[ADDR_BITS-1:0];
                    iss_next  = iss_reg + 1'b1;
                    v1_next   = 1'b1;
                    idx1_next = iss_reg[ADDR_BITS-1:0];
                end
                else
                begin
                    v1_next = 1'b0;
                end

                if (v1_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = idx1_reg - 1'b1;
                    ram_wdata = ram_rdata;
                end

                if ((iss_reg == occ_reg) && !v1_reg)
                begin
                    state_next  = sstf_pkg::SEQ_IDLE;
                    done_next   = 1'b1;
                    status_next = sstf_pkg::STATUS_DISPATCHED;
                    sector_next = best_data_reg[DATA_BITS-1:TAG_BITS];
                    tag_next    = best_data_reg[TAG_BITS-1:0];
                    seek_next   = best_dist_reg;
                    occ_next    = occ_reg - 1'b1;
                    pend_next   = occ_reg - 1'b1;
                    head_next   = best_data_reg[DATA_BITS-1:TAG_BITS];
                end
            end

            default:
            begin
                state_next = sstf_pkg::SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= sstf_pkg::SEQ_IDLE;
            occ_reg        <= '0;
            head_reg       <= '0;
            iss_reg        <= '0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            best_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            occ_reg        <= occ_next;
            head_reg       <= head_next;
            iss_reg        <= iss_next;
            v1_reg         <= v1_next;
            v2_reg         <= v2_next;
            best_valid_reg <= best_valid_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx1_reg      <= idx1_next;
        idx2_reg      <= idx2_next;
        dist_reg      <= dist_next;
        data2_reg     <= data2_next;
        best_idx_reg  <= best_idx_next;
        best_dist_reg <= best_dist_next;
        best_data_reg <= best_data_next;
        status_reg    <= status_next;
        sector_reg    <= sector_next;
        tag_reg       <= tag_next;
        seek_reg      <= seek_next;
        pend_reg      <= pend_next;
    end

    assign busy          = (state_reg != sstf_pkg::SEQ_IDLE);
    assign done          = done_reg;
    assign status        = status_reg;
    assign chosen_sector = sector_reg;
    assign chosen_tag    = tag_reg;
    assign seek_distance = seek_reg;
    assign pending_count = pend_reg;

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobed while sequencer busy");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_BITS'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_dispatch_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (op == sstf_pkg::OP_DISPATCH) && (occ_reg != '0)) |=> busy)
        else $error("dispatch on non-empty queue did not start scan");

    a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && (state_reg == sstf_pkg::SEQ_SHIFT)) |-> (CNT_BITS'(ram_waddr) < occ_reg))
        else $error("compaction write outside occupied slots");

    a_dispatch_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == sstf_pkg::STATUS_DISPATCHED)) |-> (pending_count == occ_reg))
        else $error("pending count disagrees with queue count");

endmodule

/* tb/sv/tb_sstf_request_scheduler.sv */
// Self-checking testbench for the shortest-seek-time-first request scheduler.
`timescale 1ns / 1ps

module tb_sstf_request_scheduler;

    localparam int DEPTH      = sstf_pkg::DEF_QUEUE_DEPTH;
    localparam int SECTOR_W   = sstf_pkg::DEF_SECTOR_BITS;
    localparam int TAG_W      = sstf_pkg::DEF_TAG_BITS;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int STALL_LIMIT = 3000;
    localparam logic [SECTOR_W-1:0] SECTOR_MAX = '1;

    typedef struct packed {
        logic [1:0]          status;
        logic [SECTOR_W-1:0] sector;
        logic [TAG_W-1:0]    tag;
        logic [SECTOR_W-1:0] distance;
        logic [CNT_W-1:0]    count;
    } response_t;

    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } traffic_mix_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic                op;
    logic [SECTOR_W-1:0] request_sector;
    logic [TAG_W-1:0]    request_tag;
    logic                done;
    logic [1:0]          status;
    logic [SECTOR_W-1:0] chosen_sector;
    logic [TAG_W-1:0]    chosen_tag;
    logic [SECTOR_W-1:0] seek_distance;
    logic [CNT_W-1:0]    pending_count;

    // scheduler state as predicted
    logic [SECTOR_W-1:0] model_sectors[$];
    logic [TAG_W-1:0]    model_tags[$];
    logic [SECTOR_W-1:0] model_head;

    response_t pending_responses[$];

    int idle_pct;
    int stall_cycles = 0;
    int mismatches = 0;
    int transfers;
    int adds_taken;
    int adds_refused;
    int dispatches;
    int empty_dispatches;
    int tie_breaks;

    sstf_request_scheduler dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .op             (op),
        .request_sector (request_sector),
        .request_tag    (request_tag),
        .done           (done),
        .status         (status),
        .chosen_sector  (chosen_sector),
        .chosen_tag     (chosen_tag),
        .seek_distance  (seek_distance),
        .pending_count  (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [SECTOR_W-1:0] gap(input logic [SECTOR_W-1:0] a,
                                                 input logic [SECTOR_W-1:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    function automatic response_t compute_response(input logic op_i,
                                                   input logic [SECTOR_W-1:0] sec,
                                                   input logic [TAG_W-1:0] tg);
        response_t r;
        int best;
        int nearest;
        logic [SECTOR_W-1:0] best_gap;
        r = '0;
        if (op_i == sstf_pkg::OP_ADD)
        begin
            if (model_sectors.size() < DEPTH)
            begin
                model_sectors.push_back(sec);
                model_tags.push_back(tg);
                r.status = sstf_pkg::STATUS_ADDED;
                adds_taken++;
            end
            else
            begin
                r.status = sstf_pkg::STATUS_FULL;
                adds_refused++;
            end
        end
        else if (model_sectors.size() == 0)
        begin
            r.status = sstf_pkg::STATUS_EMPTY;
            empty_dispatches++;
        end
        else
        begin
            best = 0;
            best_gap = gap(model_head, model_sectors[0]);
            for (int i = 1; i < model_sectors.size(); i++)
            begin
                if (gap(model_head, model_sectors[i]) < best_gap)
                begin
                    best_gap = gap(model_head, model_sectors[i]);
                    best = i;
                end
            end
            nearest = 0;
            foreach (model_sectors[i])
                if (gap(model_head, model_sectors[i]) == best_gap)
                    nearest++;
            if (nearest > 1)
                tie_breaks++;
            r.status   = sstf_pkg::STATUS_DISPATCHED;
            r.sector   = model_sectors[best];
            r.tag      = model_tags[best];
            r.distance = best_gap;
            model_head = model_sectors[best];
            model_sectors.delete(best);
            model_tags.delete(best);
            dispatches++;
        end
        r.count = CNT_W'(model_sectors.size());
        return r;
    endfunction

    // one command transfer, then an optional idle gap on the sending side
    task automatic send_request(input logic op_i, input logic [SECTOR_W-1:0] sec,
                                input logic [TAG_W-1:0] tg);
        int pause;
        start          <= 1'b1;
        op             <= op_i;
        request_sector <= sec;
        request_tag    <= tg;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_responses.push_back(compute_response(op_i, sec, tg));
        transfers++;
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            pause = ($urandom_range(7) == 0) ? $urandom_range(10, 80) : $urandom_range(1, 4);
            repeat (pause) @(posedge clk);
        end
    endtask

    function automatic logic [SECTOR_W-1:0] random_sector();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[SECTOR_W-1:0];
    endfunction

    function automatic logic [SECTOR_W-1:0] pick_sector();
        logic [SECTOR_W-1:0] s;
        case ($urandom_range(9))
            0, 1, 2: s = random_sector();
            3, 4, 5: s = model_head + SECTOR_W'($urandom_range(16)) - SECTOR_W'(8);
            6, 7:    s = SECTOR_W'($urandom_range(63));
            8:       s = $urandom_range(1) ? SECTOR_MAX - SECTOR_W'($urandom_range(1))
                                           : SECTOR_W'($urandom_range(1));
            default: s = (model_sectors.size() != 0)
                         ? model_sectors[$urandom_range(model_sectors.size() - 1)]
                         : random_sector();
        endcase
        return s;
    endfunction

    task automatic test_empty_dispatch();
        send_request(sstf_pkg::OP_DISPATCH, '0, '0);
        send_request(sstf_pkg::OP_DISPATCH, SECTOR_MAX, '1);
    endtask

    task automatic test_sector_extremes();
        send_request(sstf_pkg::OP_ADD, SECTOR_MAX, '1);
        send_request(sstf_pkg::OP_ADD, '0, '0);
        send_request(sstf_pkg::OP_DISPATCH, random_sector(), TAG_W'($urandom));
        send_request(sstf_pkg::OP_DISPATCH, '0, '0);
        send_request(sstf_pkg::OP_ADD, '0, 8'h5a);
        send_request(sstf_pkg::OP_DISPATCH, SECTOR_MAX, '1);
        send_request(sstf_pkg::OP_DISPATCH, '0, '0);
    endtask

    // equal distance on both sides of the head, and repeated sectors
    task automatic test_equal_distance();
        send_request(sstf_pkg::OP_ADD, 48'd1000, 8'h11);
        send_request(sstf_pkg::OP_DISPATCH, '0, '0);
        send_request(sstf_pkg::OP_ADD, 48'd1010, 8'h01);
        send_request(sstf_pkg::OP_ADD, 48'd990, 8'h02);
        send_request(sstf_pkg::OP_ADD, 48'd990, 8'h03);
        send_request(sstf_pkg::OP_ADD, 48'd1010, 8'h04);
        repeat (4) send_request(sstf_pkg::OP_DISPATCH, random_sector(), TAG_W'($urandom));
    endtask

    task automatic test_full_queue();
        repeat (DEPTH) send_request(sstf_pkg::OP_ADD, random_sector(), TAG_W'($urandom));
        send_request(sstf_pkg::OP_ADD, SECTOR_MAX, '1);
        send_request(sstf_pkg::OP_ADD, random_sector(), TAG_W'($urandom));
        send_request(sstf_pkg::OP_DISPATCH, '0, '0);
    endtask

    task automatic test_random_traffic(input int items, input int pct);
        traffic_mix_t mix;
        int run_left;
        int add_pct;
        idle_pct = pct;
        run_left = 0;
        mix = MIX_EVEN;
        repeat (items)
        begin
            if (run_left == 0)
            begin
                mix = traffic_mix_t'($urandom_range(2));
                run_left = $urandom_range(10, 60);
            end
            run_left--;
            case (mix)
                MIX_FILL:  add_pct = 85;
                MIX_DRAIN: add_pct = 15;
                default:   add_pct = 50;
            endcase
            if ($urandom_range(99) < add_pct)
                send_request(sstf_pkg::OP_ADD, pick_sector(), TAG_W'($urandom));
            else
                send_request(sstf_pkg::OP_DISPATCH, random_sector(), TAG_W'($urandom));
        end
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : check_result
        response_t want;
        if (rst_n && done)
        begin
            if (pending_responses.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual status %0d",
                         $time, status);
                mismatches++;
            end
            else
            begin
                want = pending_responses.pop_front();
                compare_field("status", 64'(want.status), 64'(status));
                compare_field("chosen_sector", 64'(want.sector), 64'(chosen_sector));
                compare_field("chosen_tag", 64'(want.tag), 64'(chosen_tag));
                compare_field("seek_distance", 64'(want.distance), 64'(seek_distance));
                compare_field("pending_count", 64'(want.count), 64'(pending_count));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("sstf_request_scheduler regression: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        op             = sstf_pkg::OP_ADD;
        request_sector = '0;
        request_tag    = '0;
        model_head     = '0;
        idle_pct       = 0;
        transfers      = 0;
        adds_taken     = 0;
        adds_refused   = 0;
        dispatches     = 0;
        empty_dispatches = 0;
        tie_breaks     = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_dispatch();
        test_sector_extremes();
        test_equal_distance();
        test_full_queue();
        test_random_traffic(300, 0);
        test_random_traffic(300, 88);
        test_random_traffic(300, 19);
        test_random_traffic(300, 0);

        start <= 1'b0;
        while (pending_responses.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("%0d transfers: %0d adds, %0d refused on a full queue, %0d dispatches,",
                 transfers, adds_taken, adds_refused, dispatches);
        $display("%0d dispatches on an empty queue, %0d picks among equally near requests",
                 empty_dispatches, tie_breaks);
        if (mismatches == 0)
            $display("sstf_request_scheduler regression: pass");
        else
            $display("sstf_request_scheduler regression: fail");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/sstf_pkg.sv
rtl/core/sstf_ram.sv
rtl/core/sstf_request_scheduler.sv
tb/sv/tb_sstf_request_scheduler.sv
